// ===== rtl/core/ocel_pkg.sv =====
// ----------------------------------------------------------------------------
// ocel_pkg: shared types and codes for the occupancy cell evidence store
// Cell record layout, operation, state, source and CSR codes, divider handshake types.
// ----------------------------------------------------------------------------
package ocel_pkg;
   localparam logic [1:0] OP_FREE   = 2'd0;
   localparam logic [1:0] OP_OCC    = 2'd1;
   localparam logic [1:0] OP_EXPIRE = 2'd2;
   localparam logic [1:0] OP_READ   = 2'd3;

   localparam logic [1:0] ST_UNKNOWN  = 2'd0;
   localparam logic [1:0] ST_FREE     = 2'd1;
   localparam logic [1:0] ST_OCCUPIED = 2'd2;

   localparam logic [2:0] SRC_SENSOR  = 3'd1;
   localparam logic [2:0] SRC_MODEL   = 3'd2;
   localparam logic [2:0] SRC_DYNAMIC = 3'd4;

   localparam logic [1:0] CSR_FREE_TO_CLEAR = 2'd0;
   localparam logic [1:0] CSR_DYN_EXPIRY    = 2'd1;
   localparam logic [1:0] CSR_HITS_DYNAMIC  = 2'd2;

   localparam logic [12:0] EXPIRED_MAX = 13'd8191;

   typedef struct packed {
      logic [1:0]  state;
      logic [15:0] free_cnt;
      logic [15:0] occ_cnt;
      logic        conflict;
      logic        dynamic;
      logic [15:0] conf;
      logic [2:0]  src;
      logic [31:0] seq;
   } cell_type;

   // divider handshake
   typedef struct packed {
      logic        start;
      logic [15:0] win;
      logic [16:0] total;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [15:0] quo;
   } div_rsp_type;
endpackage

// ===== rtl/core/ocel_divider.sv =====
// ----------------------------------------------------------------------------
// ocel_divider: serial restoring divider for the confidence share
// Computes min(65535, floor(win * 65536 / total)), one quotient bit a cycle; a zero total gives 0.
// ----------------------------------------------------------------------------
module ocel_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  ocel_pkg::div_req_type div_req,
   output ocel_pkg::div_rsp_type div_rsp
);
   // win <= total always, so quotient fits in 17 bits
   logic [17:0] rem_ff, rem_in;
   logic [16:0] quo_ff, quo_in;
   logic [16:0] den_ff, den_in;
   logic [31:0] num_ff, num_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [17:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      num_in  = num_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[16:0], num_ff[31]} - {1'b0, den_ff};
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = '0;
         den_in  = div_req.total;
         num_in  = {div_req.win, 16'd0};
         cnt_in  = 6'd32;
         busy_in = (div_req.total != 17'd0);
         done_in = (div_req.total == 17'd0);
      end else if (busy_ff) begin
         if (!trial[17]) begin
            rem_in = trial;
            quo_in = {quo_ff[15:0], 1'b1};
         end else begin
            rem_in = {rem_ff[16:0], num_ff[31]};
            quo_in = {quo_ff[15:0], 1'b0};
         end
         num_in = {num_ff[30:0], 1'b0};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      num_ff <= num_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff[16] ? 16'hFFFF : quo_ff[15:0];
endmodule

// ===== rtl/core/occupancy_cell_evidence_update.sv =====
// ----------------------------------------------------------------------------
// occupancy_cell_evidence_update: occupancy grid evidence store
// Sequencer, cell memory and a shared serial divider for confidence.
// ----------------------------------------------------------------------------
// Usage: a request on req_* (valid/ready) carries operation, cell_index and
// sequence_req. Each request yields exactly one response on rsp_*.
// Free/occupied: read cell, update, 32-step serial divide for confidence,
// write back. Read: read cell, then respond.
// Expire sweep: each cell in turn is read, then checked and written back.
// Out-of-range index returns zeros.
// One request at a time; req_ready is low while a request is being worked
// or its response waits. The response register holds until rsp_ready.
// Reset: the cell memory is cleared by a pass over all CELL_COUNT cells, one cell
// a cycle; req_ready stays low during it. Configuration writes through csr_*
// are taken at any time and assume the block is idle.
// ----------------------------------------------------------------------------
module occupancy_cell_evidence_update #(
   parameter int CELL_COUNT = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [11:0] req_cell_index,
   input  logic [31:0] req_sequence_req,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_cell_state,
   output logic [15:0] rsp_free_count,
   output logic [15:0] rsp_occupied_count,
   output logic        rsp_conflict_flag,
   output logic        rsp_dynamic_flag,
   output logic [15:0] rsp_confidence,
   output logic [2:0]  rsp_source_flags,
   output logic [31:0] rsp_last_sequence,
   output logic [12:0] rsp_expired_count,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);
   localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
   localparam logic [AW:0] LAST_CELL = (AW+1)'(CELL_COUNT - 1);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_RD     = 4'd2;
   localparam logic [3:0] S_UPD    = 4'd3;
   localparam logic [3:0] S_DIV    = 4'd4;
   localparam logic [3:0] S_SW_RD  = 4'd5;
   localparam logic [3:0] S_SW_CHK = 4'd6;
   localparam logic [3:0] S_RESP   = 4'd7;

   // configuration
   logic [15:0] ftc_ff, dexp_ff;
   logic        hdyn_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         ftc_ff  <= 16'd3;
         dexp_ff <= 16'd10;
         hdyn_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            ocel_pkg::CSR_FREE_TO_CLEAR: ftc_ff  <= csr_write_data;
            ocel_pkg::CSR_DYN_EXPIRY:    dexp_ff <= csr_write_data;
            ocel_pkg::CSR_HITS_DYNAMIC:  hdyn_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // cell memory: one write port and one read port, registered read
   ocel_pkg::cell_type mem [CELL_COUNT];
   ocel_pkg::cell_type rd_ff;
   logic               we;
   logic [AW-1:0]      waddr, raddr;
   ocel_pkg::cell_type wdata;
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   logic [3:0]         state_ff, state_in;
   logic [AW:0]        ptr_ff, ptr_in;
   logic [1:0]         op_ff, op_in;
   logic [31:0]        seq_ff, seq_in;
   ocel_pkg::cell_type cell_ff, cell_in;
   logic [12:0]        exp_ff, exp_in;
   ocel_pkg::cell_type out_ff, out_in;
   logic [12:0]        oexp_ff, oexp_in;
   logic               ovld_ff, ovld_in;
   ocel_pkg::div_req_type div_req;
   ocel_pkg::div_rsp_type div_rsp;

   ocel_divider u_div (.clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp));

   logic [15:0] f_new, o_new;
   logic [16:0] thr;
   logic [31:0] age;
   logic        stale;

   always_comb begin
      state_in = state_ff;
      ptr_in   = ptr_ff;
      op_in    = op_ff;
      seq_in   = seq_ff;
      cell_in  = cell_ff;
      exp_in   = exp_ff;
      out_in   = out_ff;
      oexp_in  = oexp_ff;
      ovld_in  = ovld_ff;
      we       = 1'b0;
      waddr    = ptr_ff[AW-1:0];
      raddr    = ptr_ff[AW-1:0];
      wdata    = '0;
      div_req  = '0;
      f_new    = '0;
      o_new    = '0;
      thr      = '0;
      age      = seq_ff - rd_ff.seq;
      stale    = rd_ff.dynamic && (seq_ff >= rd_ff.seq) && (age >= {16'd0, dexp_ff});
      if (ovld_ff && rsp_ready) ovld_in = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            we = 1'b1;
            if (ptr_ff == LAST_CELL) begin
               state_in = S_IDLE;
            end
            ptr_in = ptr_ff + 1'b1;
         end
         S_IDLE: begin
            if (req_valid && !ovld_ff) begin
               op_in  = req_operation;
               seq_in = req_sequence_req;
               exp_in = '0;
               ptr_in = (req_operation == ocel_pkg::OP_EXPIRE) ? '0 :
                        (AW+1)'(req_cell_index);
               if (req_operation == ocel_pkg::OP_EXPIRE) begin
                  state_in = S_SW_RD;
               end else if ({20'd0, req_cell_index} >= 32'(CELL_COUNT)) begin
                  cell_in  = '0;
                  state_in = S_RESP;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_RD: state_in = S_UPD;
         S_UPD: begin
            cell_in = rd_ff;
            if (op_ff == ocel_pkg::OP_READ) begin
               state_in = S_RESP;
            end else begin
               f_new = rd_ff.free_cnt;
               o_new = rd_ff.occ_cnt;
               if (op_ff == ocel_pkg::OP_FREE) begin
                  if (f_new != 16'hFFFF) f_new = f_new + 16'd1;
                  thr = {1'b0, o_new} + {1'b0, ftc_ff};
                  cell_in.conflict = (o_new != 16'd0);
                  if (rd_ff.state != ocel_pkg::ST_OCCUPIED || {1'b0, f_new} >= thr) begin
                     cell_in.state   = ocel_pkg::ST_FREE;
                     cell_in.dynamic = 1'b0;
                  end
                  cell_in.src = ocel_pkg::SRC_SENSOR | ocel_pkg::SRC_MODEL;
                  div_req.win = (f_new > o_new) ? f_new : o_new;
               end else begin
                  if (o_new != 16'hFFFF) o_new = o_new + 16'd1;
                  cell_in.state    = ocel_pkg::ST_OCCUPIED;
                  cell_in.conflict = (f_new != 16'd0);
                  cell_in.dynamic  = hdyn_ff;
                  cell_in.src = ocel_pkg::SRC_SENSOR | ocel_pkg::SRC_MODEL |
                                (hdyn_ff ? ocel_pkg::SRC_DYNAMIC : 3'd0);
                  div_req.win = o_new;
               end
               cell_in.free_cnt = f_new;
               cell_in.occ_cnt  = o_new;
               cell_in.seq      = seq_ff;
               div_req.start    = 1'b1;
               div_req.total    = {1'b0, f_new} + {1'b0, o_new};
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               cell_in.conf = div_rsp.quo;
               we       = 1'b1;
               wdata    = cell_in;
               state_in = S_RESP;
            end
         end
         S_SW_RD: state_in = S_SW_CHK;
         S_SW_CHK: begin
            if (stale) begin
               wdata          = rd_ff;
               wdata.occ_cnt  = '0;
               wdata.dynamic  = 1'b0;
               wdata.conflict = 1'b0;
               if (rd_ff.free_cnt != 16'd0) begin
                  wdata.state = ocel_pkg::ST_FREE;
                  wdata.conf  = 16'hFFFF;
                  wdata.src   = ocel_pkg::SRC_MODEL;
               end else begin
                  wdata.state = ocel_pkg::ST_UNKNOWN;
                  wdata.conf  = '0;
                  wdata.src   = '0;
               end
               we = 1'b1;
               if (exp_ff != ocel_pkg::EXPIRED_MAX) exp_in = exp_ff + 13'd1;
            end
            if (ptr_ff == LAST_CELL) begin
               cell_in  = '0;
               state_in = S_RESP;
            end else begin
               ptr_in   = ptr_ff + 1'b1;
               raddr    = ptr_in[AW-1:0];
               state_in = S_SW_RD;
            end
         end
         S_RESP: begin
            out_in   = cell_ff;
            oexp_in  = exp_ff;
            ovld_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ptr_ff   <= '0;
         ovld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         ovld_ff  <= ovld_in;
      end
      op_ff   <= op_in;
      seq_ff  <= seq_in;
      cell_ff <= cell_in;
      exp_ff  <= exp_in;
      out_ff  <= out_in;
      oexp_ff <= oexp_in;
   end

   assign req_ready          = (state_ff == S_IDLE) && !ovld_ff;
   assign rsp_valid          = ovld_ff;
   assign rsp_cell_state     = out_ff.state;
   assign rsp_free_count     = out_ff.free_cnt;
   assign rsp_occupied_count = out_ff.occ_cnt;
   assign rsp_conflict_flag  = out_ff.conflict;
   assign rsp_dynamic_flag   = out_ff.dynamic;
   assign rsp_confidence     = out_ff.conf;
   assign rsp_source_flags   = out_ff.src;
   assign rsp_last_sequence  = out_ff.seq;
   assign rsp_expired_count  = oexp_ff;

   a_no_ready_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready) else $error("ready while busy");
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("response dropped");
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != S_IDLE)) else $error("request lost");
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !we) else $error("memory write while idle");
endmodule
